[src/rhc_pkg.sv]
// Shared widths, hue constants and item types for the RGB to HSV converter.
package rhc_pkg;

	// Channel width and derived widths
	localparam int CHAN_W = 8;
	localparam int HUE_W  = 15;
	// Quotient bits of the hue term; the term never exceeds one sixth of the circle
	localparam int HQ_W   = 12;
	localparam int HNUM_W = HQ_W + CHAN_W;
	localparam int NSTAGE = (HQ_W > CHAN_W) ? HQ_W : CHAN_W;

	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	// Hue scale: 64 units per degree
	localparam logic [HQ_W-1:0]  HUE_SIXTH     = HQ_W'(3840);
	localparam logic [HUE_W-1:0] HUE_OFS_RED   = '0;
	localparam logic [HUE_W-1:0] HUE_OFS_GREEN = HUE_W'(7680);
	localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = HUE_W'(15360);
	localparam logic [HUE_W-1:0] HUE_FULL      = HUE_W'(23040);
	localparam logic [HUE_W-1:0] HUE_MAX       = HUE_W'(23039);

	// Queue between the classifier and the divider pipeline
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = $clog2(MQ_DEPTH);

	// Result queue; deep enough to cover the whole divider pipeline in flight
	localparam int OQ_DEPTH = 2 ** $clog2(NSTAGE + 4);
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Classified pixel handed from front to back
	typedef struct packed {
		logic [2*CHAN_W-1:0] s_num;
		logic [CHAN_W-1:0]   mx;
		logic [HNUM_W-1:0]   h_num;
		logic [CHAN_W-1:0]   delta;
		logic                neg;
		logic                grey;
		logic [HUE_W-1:0]    ofs;
	} cls_t;

	// Finished result
	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
	} res_t;

endpackage

[src/rgb_to_hsv_convert.sv]
// Top level of the RGB to HSV pixel converter.
// Converts one pixel of three unsigned channels to hue (1/64 degree units,
// 0 to 23039), saturation ((max-min)*255/max, truncated) and value (largest
// channel), with no state carried between pixels. Both sides look like a
// queue: write a pixel with push while full is low; read the oldest result
// while empty is low and take it with pop. One pixel per clock is sustained
// for as long as results are popped at the same pace. On its way to the
// result ports, a pixel is written by the classifier into a four-entry
// queue, then walks a twelve-stage restoring divider that yields one hue
// quotient bit per stage and one saturation quotient bit per stage until
// its eight bits are done, and the finished result lands in a sixteen-entry
// result queue. The divider pipeline only admits a pixel while a result slot
// is reserved for it, so the pipeline never stalls; when the reader holds off,
// the result queue fills, then the front queue fills and full rises.
module rgb_to_hsv_convert (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [rhc_pkg::CHAN_W-1:0] red,
	input  logic [rhc_pkg::CHAN_W-1:0] green,
	input  logic [rhc_pkg::CHAN_W-1:0] blue,
	output logic                       empty,
	input  logic                       pop,
	output logic [rhc_pkg::HUE_W-1:0]  hue,
	output logic [rhc_pkg::CHAN_W-1:0] saturation,
	output logic [rhc_pkg::CHAN_W-1:0] brightness
);

	rhc_pkg::cls_t cls;
	rhc_pkg::cls_t mq_item;
	logic          mq_empty;
	logic          mq_pop;
	rhc_pkg::res_t res;

	// Classify the incoming pixel: extremes, sector, dividends
	rhc_front u_front (
		.red   (red),
		.green (green),
		.blue  (blue),
		.cls   (cls)
	);

	// Hold classified pixels until the divider pipeline has room
	rhc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (cls),
		.full    (full),
		.rd_en   (mq_pop),
		.rd_item (mq_item),
		.empty   (mq_empty)
	);

	// Divide, assemble hue and queue the results
	rhc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (mq_empty),
		.in_pop   (mq_pop),
		.in_item  (mq_item),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign hue        = res.hue;
	assign saturation = res.sat;
	assign brightness = res.val;

endmodule

[src/rhc_front.sv]
// Pixel classifier: largest and smallest channel, hue sector, dividends and divisors.
module rhc_front (
	input  logic [rhc_pkg::CHAN_W-1:0] red,
	input  logic [rhc_pkg::CHAN_W-1:0] green,
	input  logic [rhc_pkg::CHAN_W-1:0] blue,
	output rhc_pkg::cls_t              cls
);

	logic [rhc_pkg::CHAN_W-1:0] mx;
	logic [rhc_pkg::CHAN_W-1:0] mn;
	logic [rhc_pkg::CHAN_W-1:0] opa;
	logic [rhc_pkg::CHAN_W-1:0] opb;
	logic [rhc_pkg::CHAN_W-1:0] diff;
	logic [rhc_pkg::CHAN_W-1:0] delta;
	logic [rhc_pkg::HUE_W-1:0]  ofs;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		// Sector by largest channel, red over green over blue on ties
		if (red == mx) begin
			opa = green;
			opb = blue;
			ofs = rhc_pkg::HUE_OFS_RED;
		end else if (green == mx) begin
			opa = blue;
			opb = red;
			ofs = rhc_pkg::HUE_OFS_GREEN;
		end else begin
			opa = red;
			opb = green;
			ofs = rhc_pkg::HUE_OFS_BLUE;
		end

		diff  = (opa >= opb) ? (opa - opb) : (opb - opa);
		delta = mx - mn;

		cls.s_num = {{rhc_pkg::CHAN_W{1'b0}}, delta} * {{rhc_pkg::CHAN_W{1'b0}}, rhc_pkg::CHAN_MAX};
		cls.mx    = mx;
		cls.h_num = {{rhc_pkg::HQ_W{1'b0}}, diff} * {{rhc_pkg::CHAN_W{1'b0}}, rhc_pkg::HUE_SIXTH};
		cls.delta = delta;
		cls.neg   = (opa < opb);
		cls.grey  = (mx == mn);
		cls.ofs   = ofs;
	end

endmodule

[src/rhc_queue.sv]
// Short queue of classified pixels between the classifier and the divider pipeline.
module rhc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rhc_pkg::cls_t wr_item,
	output logic          full,
	input  logic          rd_en,
	output rhc_pkg::cls_t rd_item,
	output logic          empty
);

	rhc_pkg::cls_t                mem_q [rhc_pkg::MQ_DEPTH];
	logic [rhc_pkg::MQ_AW-1:0]    wr_ptr_q;
	logic [rhc_pkg::MQ_AW-1:0]    rd_ptr_q;
	logic [rhc_pkg::MQ_AW:0]      cnt_q;
	logic                         do_wr;
	logic                         do_rd;

	assign full    = (cnt_q == (rhc_pkg::MQ_AW+1)'(rhc_pkg::MQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (!do_wr && do_rd) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

[src/rhc_back.sv]
// Divider pipeline for hue and saturation, hue assembly and the result queue.
module rhc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_empty,
	output logic          in_pop,
	input  rhc_pkg::cls_t in_item,
	input  logic          pop,
	output logic          empty,
	output rhc_pkg::res_t res
);

	typedef struct packed {
		logic [rhc_pkg::CHAN_W-1:0] h_rem;
		logic [rhc_pkg::HQ_W-1:0]   h_lo;
		logic [rhc_pkg::HQ_W-1:0]   h_q;
		logic [rhc_pkg::CHAN_W-1:0] delta;
		logic [rhc_pkg::CHAN_W-1:0] s_rem;
		logic [rhc_pkg::CHAN_W-1:0] s_lo;
		logic [rhc_pkg::CHAN_W-1:0] s_q;
		logic [rhc_pkg::CHAN_W-1:0] mx;
		logic                       neg;
		logic                       grey;
		logic [rhc_pkg::HUE_W-1:0]  ofs;
	} stg_t;

	// One restoring division step: bring in one dividend bit, subtract if it fits
	function automatic logic [rhc_pkg::CHAN_W:0] div_step(
		input logic [rhc_pkg::CHAN_W-1:0] rem,
		input logic                       nbit,
		input logic [rhc_pkg::CHAN_W-1:0] dvs
	);
		logic [rhc_pkg::CHAN_W:0] t;
		logic [rhc_pkg::CHAN_W:0] d;
		logic                     ge;
		t  = {rem, nbit};
		d  = t - {1'b0, dvs};
		ge = (t >= {1'b0, dvs});
		// upper bit: quotient bit; lower bits: new remainder
		return {ge, ge ? d[rhc_pkg::CHAN_W-1:0] : t[rhc_pkg::CHAN_W-1:0]};
	endfunction

	stg_t                        stg_q [rhc_pkg::NSTAGE+1];
	stg_t                        nxt   [rhc_pkg::NSTAGE];
	logic [rhc_pkg::NSTAGE:0]    vld_q;
	logic [rhc_pkg::OQ_AW:0]     used_q;
	logic                        take;
	logic                        deq;

	rhc_pkg::res_t               oq_q [rhc_pkg::OQ_DEPTH];
	logic [rhc_pkg::OQ_AW-1:0]   owp_q;
	logic [rhc_pkg::OQ_AW-1:0]   orp_q;
	logic [rhc_pkg::OQ_AW:0]     ocnt_q;
	rhc_pkg::res_t               fin;
	stg_t                        last;
	logic [rhc_pkg::HUE_W:0]     mag;
	logic [rhc_pkg::HUE_W:0]     hsum;

	// Take a pixel only while a result slot is reserved for it
	assign take   = !in_empty && (used_q < (rhc_pkg::OQ_AW+1)'(rhc_pkg::OQ_DEPTH));
	assign in_pop = take;
	assign empty  = (ocnt_q == '0);
	assign deq    = pop && !empty;
	assign res    = oq_q[orp_q];

	generate
		for (genvar j = 0; j < rhc_pkg::NSTAGE; j++) begin : g_stage
			logic [rhc_pkg::CHAN_W:0] hs;
			logic [rhc_pkg::CHAN_W:0] ss;
			if (j < rhc_pkg::HQ_W) begin : g_hue
				assign hs = div_step(stg_q[j].h_rem, stg_q[j].h_lo[rhc_pkg::HQ_W-1-j],
					stg_q[j].delta);
			end else begin : g_hue_idle
				assign hs = {1'b0, stg_q[j].h_rem};
			end
			if (j < rhc_pkg::CHAN_W) begin : g_sat
				assign ss = div_step(stg_q[j].s_rem, stg_q[j].s_lo[rhc_pkg::CHAN_W-1-j],
					stg_q[j].mx);
			end else begin : g_sat_idle
				assign ss = {1'b0, stg_q[j].s_rem};
			end

			always_comb begin
				nxt[j] = stg_q[j];
				if (j < rhc_pkg::HQ_W) begin
					nxt[j].h_rem = hs[rhc_pkg::CHAN_W-1:0];
					nxt[j].h_q   = {stg_q[j].h_q[rhc_pkg::HQ_W-2:0], hs[rhc_pkg::CHAN_W]};
				end
				if (j < rhc_pkg::CHAN_W) begin
					nxt[j].s_rem = ss[rhc_pkg::CHAN_W-1:0];
					nxt[j].s_q   = {stg_q[j].s_q[rhc_pkg::CHAN_W-2:0], ss[rhc_pkg::CHAN_W]};
				end
			end

			always_ff @(posedge clk) begin
				stg_q[j+1] <= nxt[j];
			end
		end
	endgenerate

	// Load the first stage from the queue head
	always_ff @(posedge clk) begin
		stg_q[0].h_rem <= in_item.h_num[rhc_pkg::HNUM_W-1:rhc_pkg::HQ_W];
		stg_q[0].h_lo  <= in_item.h_num[rhc_pkg::HQ_W-1:0];
		stg_q[0].h_q   <= '0;
		stg_q[0].delta <= in_item.delta;
		stg_q[0].s_rem <= in_item.s_num[2*rhc_pkg::CHAN_W-1:rhc_pkg::CHAN_W];
		stg_q[0].s_lo  <= in_item.s_num[rhc_pkg::CHAN_W-1:0];
		stg_q[0].s_q   <= '0;
		stg_q[0].mx    <= in_item.mx;
		stg_q[0].neg   <= in_item.neg;
		stg_q[0].grey  <= in_item.grey;
		stg_q[0].ofs   <= in_item.ofs;
	end

	// Hue assembly: zero for grey, else offset plus or minus the term, wrapped into one turn
	always_comb begin
		last = stg_q[rhc_pkg::NSTAGE];
		mag  = {{(rhc_pkg::HUE_W+1-rhc_pkg::HQ_W){1'b0}}, last.h_q};
		if (last.grey) begin
			hsum = '0;
		end else if (!last.neg || (mag == '0)) begin
			hsum = {1'b0, last.ofs} + mag;
		end else if ({1'b0, last.ofs} >= mag) begin
			hsum = {1'b0, last.ofs} - mag;
		end else begin
			hsum = {1'b0, last.ofs} + {1'b0, rhc_pkg::HUE_FULL} - mag;
		end
		fin.hue = hsum[rhc_pkg::HUE_W-1:0];
		fin.sat = (last.mx == '0) ? '0 : last.s_q;
		fin.val = last.mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			used_q <= '0;
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			vld_q <= {vld_q[rhc_pkg::NSTAGE-1:0], take};
			if (take && !deq) used_q <= used_q + 1'b1;
			else if (!take && deq) used_q <= used_q - 1'b1;
			if (vld_q[rhc_pkg::NSTAGE]) owp_q <= owp_q + 1'b1;
			if (deq) orp_q <= orp_q + 1'b1;
			if (vld_q[rhc_pkg::NSTAGE] && !deq) ocnt_q <= ocnt_q + 1'b1;
			else if (!vld_q[rhc_pkg::NSTAGE] && deq) ocnt_q <= ocnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[rhc_pkg::NSTAGE]) oq_q[owp_q] <= fin;
	end

endmodule

[src/rhc_chk.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level.
module rhc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       pop,
	input logic                       empty,
	input logic [rhc_pkg::HUE_W-1:0]  hue,
	input logic [rhc_pkg::CHAN_W-1:0] saturation,
	input logic [rhc_pkg::CHAN_W-1:0] brightness
);

	// Hold the head result until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(hue) && $stable(saturation)
			&& $stable(brightness)))
		else $error("head result changed before its transaction");

	// Full only rises right after a pixel was offered
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push transaction");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (hue <= rhc_pkg::HUE_MAX))
		else $error("hue out of range");

	// Zero saturation only for a grey pixel, whose hue is zero
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (saturation == '0)) |-> (hue == '0))
		else $error("grey pixel with nonzero hue");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (brightness == '0)) |-> ((saturation == '0) && (hue == '0)))
		else $error("black pixel with nonzero saturation or hue");

endmodule

bind rgb_to_hsv_convert rhc_chk u_rhc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.pop        (pop),
	.empty      (empty),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RGB to HSV pixel converter.
module tb;
	import rhc_pkg::*;

	// Cycles without any transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// Length of the long reader hold-off that backs the block up into full
	localparam int HOLD_CYCLES    = 80;
	// Margin after the last expected result, for a stray late result
	localparam int DRAIN_CYCLES   = 32;
	localparam int N_ROWS         = 23;
	localparam int SHOW_MISMATCH  = 10;

	// One directed pixel; when typed is set, want holds the hand-computed result
	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              typed;
		res_t              want;
	} pixel_row_t;

	// Directed pixels: black, white, grey, the primaries and secondaries, ties for
	// the largest channel, the smallest nonzero value, a hue that wraps below zero,
	// then a set of ordinary colors that the predictor covers.
	localparam pixel_row_t PIXEL_ROWS [N_ROWS] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd0,   8'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     8'd0,   8'd255}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     8'd0,   8'd128}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  8'd255, 8'd255}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 8'd255, 8'd255}},
		'{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 8'd255, 8'd255}},
		'{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 8'd255, 8'd255}},
		'{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd1}},
		'{8'd255, 8'd0,   8'd1,   1'b1, '{15'd23025, 8'd255, 8'd255}},
		'{8'd0,   8'd1,   8'd1,   1'b1, '{15'd11520, 8'd255, 8'd1}},
		'{8'd254, 8'd255, 8'd255, 1'b0, '0},
		'{8'd255, 8'd254, 8'd253, 1'b0, '0},
		'{8'd1,   8'd2,   8'd3,   1'b0, '0},
		'{8'd170, 8'd85,  8'd0,   1'b0, '0},
		'{8'd0,   8'd170, 8'd85,  1'b0, '0},
		'{8'd85,  8'd0,   8'd170, 1'b0, '0},
		'{8'd10,  8'd200, 8'd250, 1'b0, '0},
		'{8'd250, 8'd10,  8'd200, 1'b0, '0},
		'{8'd170, 8'd255, 8'd170, 1'b0, '0},
		'{8'd1,   8'd254, 8'd127, 1'b0, '0},
		'{8'd255, 8'd1,   8'd128, 1'b0, '0}
	};

	localparam logic [CHAN_W-1:0] EDGE_CODES [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              empty;
	logic              pop;
	logic [HUE_W-1:0]  hue;
	logic [CHAN_W-1:0] saturation;
	logic [CHAN_W-1:0] brightness;

	// Travels alongside the pixel so the monitor knows which expectation to queue
	logic row_typed;
	res_t row_want;

	// Expected results in push order
	res_t hsv_q [$];

	int   mismatches = 0;
	int   quiet_cycles = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	logic hold_req = 1'b0;

	rgb_to_hsv_convert uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.empty      (empty),
		.pop        (pop),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predict hue, saturation and value of one pixel in plain integers.
	// Integer division truncates toward zero, which is exactly what the hue
	// term needs when the difference is negative.
	function automatic res_t hsv_of_pixel(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		int   mx;
		int   mn;
		int   delta;
		int   h;
		res_t o;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		o.val = CHAN_W'(mx);
		o.sat = (mx == 0) ? '0 : CHAN_W'(((mx - mn) * int'(CHAN_MAX)) / mx);
		h = 0;
		// Grey and black keep hue at zero
		if (mx != mn) begin
			delta = mx - mn;
			// Red beats green beats blue when channels tie for largest
			if (int'(r) == mx)
				h = int'(HUE_OFS_RED) + (int'(HUE_SIXTH) * (int'(g) - int'(b))) / delta;
			else if (int'(g) == mx)
				h = int'(HUE_OFS_GREEN) + (int'(HUE_SIXTH) * (int'(b) - int'(r))) / delta;
			else
				h = int'(HUE_OFS_BLUE) + (int'(HUE_SIXTH) * (int'(r) - int'(g))) / delta;
			// Wrap a negative hue around the circle
			if (h < 0) h += int'(HUE_FULL);
		end
		o.hue = HUE_W'(h);
		return o;
	endfunction

	// Offer one pixel and hold it until the push transaction completes.
	// Drop push for a random gap first when the sender is set to idle.
	task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b, input logic typed, input res_t want);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		push      <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Push random pixels, weighted toward greys, ties and edge codes so the
	// hue sector selection and the zero cases get hit often.
	task automatic push_random_pixels(input int count);
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] top;
		logic [CHAN_W-1:0] low;
		int                base;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: begin
					r = CHAN_W'($urandom_range(255));
					g = r;
					b = r;
				end
				1: begin
					top = CHAN_W'($urandom_range(255));
					low = CHAN_W'($urandom_range(top));
					case ($urandom_range(2))
						0: begin r = top; g = top; b = low; end
						1: begin r = low; g = top; b = top; end
						default: begin r = top; g = low; b = top; end
					endcase
				end
				2: begin
					r = EDGE_CODES[$urandom_range(3)];
					g = EDGE_CODES[$urandom_range(3)];
					b = EDGE_CODES[$urandom_range(3)];
				end
				3: begin
					// Nearly grey: tiny delta stresses the divider
					base = $urandom_range(250);
					r = CHAN_W'(base + $urandom_range(5));
					g = CHAN_W'(base + $urandom_range(5));
					b = CHAN_W'(base + $urandom_range(5));
				end
				default: begin
					r = CHAN_W'($urandom_range(255));
					g = CHAN_W'($urandom_range(255));
					b = CHAN_W'($urandom_range(255));
				end
			endcase
			send_pixel(r, g, b, 1'b0, '0);
		end
	endtask

	// Stimulus and end of run
	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		row_typed = 1'b0;
		row_want  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with both sides running flat out
		for (int i = 0; i < N_ROWS; i++)
			send_pixel(PIXEL_ROWS[i].r, PIXEL_ROWS[i].g, PIXEL_ROWS[i].b,
				PIXEL_ROWS[i].typed, PIXEL_ROWS[i].want);

		// Hold the reader off while the sender keeps offering, to fill the block
		hold_req <= 1'b1;
		push_random_pixels(60);

		// Sender idles
		tx_idle_pct = 53;
		push_random_pixels(110);

		// Receiver stalls
		tx_idle_pct  = 0;
		rx_stall_pct = 53;
		push_random_pixels(110);

		// Both sides idle
		tx_idle_pct  = 37;
		rx_stall_pct = 37;
		push_random_pixels(110);

		// No idling again
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		push_random_pixels(110);

		push <= 1'b0;
		while (hsv_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("rgb_to_hsv_convert regression: pass");
		else
			$display("rgb_to_hsv_convert regression: fail");
		$finish;
	end

	// Reader: pop at random per the stall rate, or hold off for a long stretch
	// when asked, counting the hold-off here.
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_req) begin
				hold_req  <= 1'b0;
				hold_left = HOLD_CYCLES;
				pop       <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Monitor: queue an expectation on every push transaction and check every
	// pop transaction against the oldest one.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (push && !full)
				hsv_q.push_back(row_typed ? row_want : hsv_of_pixel(red, green, blue));
			if (pop && !empty) begin
				if (hsv_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MISMATCH)
						$display("unexpected result: hue=%0d sat=%0d val=%0d",
							hue, saturation, brightness);
				end else begin
					want = hsv_q.pop_front();
					if (hue !== want.hue || saturation !== want.sat
						|| brightness !== want.val) begin
						mismatches++;
						if (mismatches <= SHOW_MISMATCH)
							$display("mismatch: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
								want.hue, want.sat, want.val, hue, saturation, brightness);
					end
				end
			end
		end
	end

	// Watchdog: give up when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("rgb_to_hsv_convert regression: fail");
			$finish;
		end
	end

endmodule
